@@ rtl/bit_offset_copy_engine_top_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the bit offset copy engine
// Included by the file that carries the concurrent checks.
// ---------------------------------------------------------------------------
`ifndef BIT_OFFSET_COPY_ENGINE_TOP_DEFINES_SVH
`define BIT_OFFSET_COPY_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BOCP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while in reset
`define BOCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/bocp_pkg.sv @@
// ---------------------------------------------------------------------------
// bocp_pkg
// Types and constants of the bit offset copy engine.
// ---------------------------------------------------------------------------
`default_nettype none

package bocp_pkg;

   typedef enum logic [1:0] {
      ACT_WR_SRC = 2'd0,
      ACT_WR_DST = 2'd1,
      ACT_RD_DST = 2'd2,
      ACT_COPY   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RD_WAIT,
      ST_CP_PRIME,
      ST_CP_RUN
   } state_type;

   localparam logic STAT_DONE      = 1'b0;
   localparam logic STAT_RANGE_ERR = 1'b1;

   localparam logic [7:0] BYTE_ONES = 8'hff;

   // control bits of one byte store port pair
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

`default_nettype wire

@@ rtl/bocp_req_if.sv @@
// ---------------------------------------------------------------------------
// bocp_req_if
// Request channel: valid/ready handshake with the request fields.
// ---------------------------------------------------------------------------
`default_nettype none

interface bocp_req_if import bocp_pkg::*; ();

   logic        valid;
   logic        ready;
   action_type  action;
   logic [7:0]  byte_addr;
   logic [7:0]  byte_data;
   logic [10:0] dst_bit;
   logic [10:0] src_bit;
   logic [11:0] copy_bits;

   modport source (
      output valid, action, byte_addr, byte_data, dst_bit, src_bit, copy_bits,
      input  ready
   );

   modport sink (
      input  valid, action, byte_addr, byte_data, dst_bit, src_bit, copy_bits,
      output ready
   );

endinterface

`default_nettype wire

@@ rtl/bocp_rsp_if.sv @@
// ---------------------------------------------------------------------------
// bocp_rsp_if
// Response channel: valid/ready handshake with read data and status.
// ---------------------------------------------------------------------------
`default_nettype none

interface bocp_rsp_if ();

   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       status;

   modport source (
      output valid, read_data, status,
      input  ready
   );

   modport sink (
      input  valid, read_data, status,
      output ready
   );

endinterface

`default_nettype wire

@@ rtl/bocp_byte_ram.sv @@
// ---------------------------------------------------------------------------
// bocp_byte_ram
// Byte-wide store, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module bocp_byte_ram import bocp_pkg::*; #(
   parameter int DEPTH = 256,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire mem_ctl_type   ctl,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [7:0]    wdata,
   input  wire logic [AW-1:0] raddr,
   output logic [7:0]         rdata
);

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_ff[waddr] <= wdata;
      end
      if (ctl.rd_en) begin
         rdata_ff <= store_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ rtl/bocp_seq.sv @@
// ---------------------------------------------------------------------------
// bocp_seq
// Request decode, copy walker and response register.
// ---------------------------------------------------------------------------
`default_nettype none

module bocp_seq import bocp_pkg::*; #(
   parameter int STORE_BYTES = 256,
   parameter int AW          = $clog2(STORE_BYTES)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   bocp_req_if.sink           req_chan,
   bocp_rsp_if.source         rsp_chan,
   output mem_ctl_type        src_ctl,
   output logic [AW-1:0]      src_waddr,
   output logic [7:0]         src_wdata,
   output logic [AW-1:0]      src_raddr,
   input  wire logic [7:0]    src_rdata,
   output mem_ctl_type        dst_ctl,
   output logic [AW-1:0]      dst_waddr,
   output logic [7:0]         dst_wdata,
   output logic [AW-1:0]      dst_raddr,
   input  wire logic [7:0]    dst_rdata
);

   localparam int TOTAL_BITS = STORE_BYTES * 8;

   state_type   state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_data_ff;
   logic        rsp_status_ff;

   logic [AW-1:0] src_idx_ff;
   logic [AW-1:0] dst_idx_ff;
   logic [9:0]    left_ff;
   logic [2:0]    off_ff;
   logic [7:0]    head_ff;
   logic [7:0]    tail_ff;
   logic          first_ff;
   logic [7:0]    win_ff;

   // request decode
   logic          req_fire;
   logic          addr_ok;
   logic          range_ok;
   logic          copy_go;
   logic          rd_go;
   logic          req_err;
   logic [12:0]   src_end;
   logic [12:0]   dst_end;
   logic [12:0]   dst_last;
   logic [12:0]   src_lead;
   logic [AW-1:0] b0;
   logic [AW-1:0] k0;
   logic [9:0]    nbytes;
   logic [7:0]    head_mask;
   logic [7:0]    tail_mask;

   // copy datapath
   logic          last_byte;
   logic [7:0]    mask;
   logic [15:0]   shifted;
   logic [7:0]    merged;

   logic          rsp_load;
   logic [7:0]    rsp_data_in;
   logic          rsp_status_in;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign addr_ok  = 32'(req_chan.byte_addr) < 32'(STORE_BYTES);
   assign src_end  = 13'(req_chan.src_bit) + 13'(req_chan.copy_bits);
   assign dst_end  = 13'(req_chan.dst_bit) + 13'(req_chan.copy_bits);
   assign dst_last = dst_end - 13'd1;
   assign range_ok = (32'(src_end) <= 32'(TOTAL_BITS)) &&
                     (32'(dst_end) <= 32'(TOTAL_BITS));

   assign copy_go = (req_chan.action == ACT_COPY) && range_ok &&
                    (req_chan.copy_bits != 12'd0);
   assign rd_go   = (req_chan.action == ACT_RD_DST) && addr_ok;
   assign req_err = (req_chan.action == ACT_COPY) ? !range_ok : !addr_ok;

   // source bit that lines up with the MSB of the first destination byte;
   // may lie before bit zero, those bits are masked off
   assign src_lead  = 13'(req_chan.src_bit) - 13'(req_chan.dst_bit[2:0]);
   assign b0        = AW'($signed(src_lead) >>> 3);
   assign k0        = AW'(req_chan.dst_bit[10:3]);
   assign nbytes    = 10'(dst_last[12:3]) - 10'(req_chan.dst_bit[10:3]) + 10'd1;
   assign head_mask = BYTE_ONES >> req_chan.dst_bit[2:0];
   assign tail_mask = BYTE_ONES << (3'd7 - dst_last[2:0]);

   // merge of one destination byte
   assign last_byte = (left_ff == 10'd1);
   assign mask      = (first_ff ? head_ff : BYTE_ONES) & (last_byte ? tail_ff : BYTE_ONES);
   assign shifted   = {win_ff, src_rdata} << off_ff;
   assign merged    = (dst_rdata & ~mask) | (shifted[15:8] & mask);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && rd_go) begin
               state_in = ST_RD_WAIT;
            end else if (req_fire && copy_go) begin
               state_in = ST_CP_PRIME;
            end
         end
         ST_RD_WAIT:  state_in = ST_IDLE;
         ST_CP_PRIME: state_in = ST_CP_RUN;
         ST_CP_RUN: begin
            if (last_byte) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_chan.ready = 1'b0;
      src_ctl        = '0;
      dst_ctl        = '0;
      src_waddr      = AW'(req_chan.byte_addr);
      src_wdata      = req_chan.byte_data;
      src_raddr      = b0;
      dst_waddr      = AW'(req_chan.byte_addr);
      dst_wdata      = req_chan.byte_data;
      dst_raddr      = AW'(req_chan.byte_addr);
      rsp_load       = 1'b0;
      rsp_data_in    = 8'd0;
      rsp_status_in  = STAT_DONE;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
            if (req_fire) begin
               src_ctl.wr_en = (req_chan.action == ACT_WR_SRC) && addr_ok;
               dst_ctl.wr_en = (req_chan.action == ACT_WR_DST) && addr_ok;
               src_ctl.rd_en = copy_go;
               dst_ctl.rd_en = rd_go;
               rsp_load      = !rd_go && !copy_go;
               rsp_status_in = req_err ? STAT_RANGE_ERR : STAT_DONE;
            end
         end
         ST_RD_WAIT: begin
            rsp_load    = 1'b1;
            rsp_data_in = dst_rdata;
         end
         ST_CP_PRIME: begin
            src_raddr     = src_idx_ff;
            dst_raddr     = dst_idx_ff;
            src_ctl.rd_en = 1'b1;
            dst_ctl.rd_en = 1'b1;
         end
         ST_CP_RUN: begin
            dst_ctl.wr_en = 1'b1;
            dst_waddr     = dst_idx_ff;
            dst_wdata     = merged;
            src_raddr     = src_idx_ff + AW'(1);
            dst_raddr     = dst_idx_ff + AW'(1);
            src_ctl.rd_en = !last_byte;
            dst_ctl.rd_en = !last_byte;
            rsp_load      = last_byte;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && copy_go) begin
               src_idx_ff <= b0 + AW'(1);
               dst_idx_ff <= k0;
               left_ff    <= nbytes;
               off_ff     <= src_lead[2:0];
               head_ff    <= head_mask;
               tail_ff    <= tail_mask;
               first_ff   <= 1'b1;
            end
         end
         ST_CP_PRIME: begin
            win_ff <= src_rdata;
         end
         ST_CP_RUN: begin
            win_ff     <= src_rdata;
            src_idx_ff <= src_idx_ff + AW'(1);
            dst_idx_ff <= dst_idx_ff + AW'(1);
            left_ff    <= left_ff - 10'd1;
            first_ff   <= 1'b0;
         end
         default: begin
            win_ff <= win_ff;
         end
      endcase
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff;
   assign rsp_chan.status    = rsp_status_ff;

endmodule

`default_nettype wire

@@ rtl/bit_offset_copy_engine_top.sv @@
// ---------------------------------------------------------------------------
// bit_offset_copy_engine_top
// Source and destination byte stores with MSB-first bit-field copy.
//
//   channel    dir   handshake          payload
//   req_chan   in    valid / ready      action, byte_addr, byte_data,
//                                       dst_bit, src_bit, copy_bits
//   rsp_chan   out   valid / ready      read_data, status
//
// Writes, refused requests and zero-length copies answer in the cycle after
// acceptance; a destination read answers once the registered store data is
// loaded into the response register. A copy primes the source window, then
// the walker does one read-merge-write of the destination store per cycle.
// One request is in flight at a time; a new one is taken only when the
// output register is empty or its response is read in the same cycle.
// Store contents are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module bit_offset_copy_engine_top import bocp_pkg::*; #(
   parameter int STORE_BYTES = 256
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bocp_req_if.sink   req_chan,
   bocp_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(STORE_BYTES);

   mem_ctl_type   src_ctl;
   mem_ctl_type   dst_ctl;
   logic [AW-1:0] src_waddr;
   logic [AW-1:0] src_raddr;
   logic [AW-1:0] dst_waddr;
   logic [AW-1:0] dst_raddr;
   logic [7:0]    src_wdata;
   logic [7:0]    src_rdata;
   logic [7:0]    dst_wdata;
   logic [7:0]    dst_rdata;

   bocp_seq #(
      .STORE_BYTES (STORE_BYTES),
      .AW          (AW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .src_ctl   (src_ctl),
      .src_waddr (src_waddr),
      .src_wdata (src_wdata),
      .src_raddr (src_raddr),
      .src_rdata (src_rdata),
      .dst_ctl   (dst_ctl),
      .dst_waddr (dst_waddr),
      .dst_wdata (dst_wdata),
      .dst_raddr (dst_raddr),
      .dst_rdata (dst_rdata)
   );

   bocp_byte_ram #(
      .DEPTH (STORE_BYTES),
      .AW    (AW)
   ) u_src_ram (
      .clock (clock),
      .ctl   (src_ctl),
      .waddr (src_waddr),
      .wdata (src_wdata),
      .raddr (src_raddr),
      .rdata (src_rdata)
   );

   bocp_byte_ram #(
      .DEPTH (STORE_BYTES),
      .AW    (AW)
   ) u_dst_ram (
      .clock (clock),
      .ctl   (dst_ctl),
      .waddr (dst_waddr),
      .wdata (dst_wdata),
      .raddr (dst_raddr),
      .rdata (dst_rdata)
   );

endmodule

`default_nettype wire

@@ rtl/bocp_checker.sv @@
// ---------------------------------------------------------------------------
// bocp_checker
// Port-level checks on the copy engine, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bit_offset_copy_engine_top_defines.svh"

module bocp_checker import bocp_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire action_type req_action,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_read_data,
   input wire logic       rsp_status
);

   action_type last_action_ff, last_action_in;
   logic       req_fire;
   logic       is_write;

   assign req_fire = req_valid && req_ready;
   assign is_write = (req_action == ACT_WR_SRC) || (req_action == ACT_WR_DST);

   always_comb begin
      last_action_in = last_action_ff;
      if (req_fire) begin
         last_action_in = req_action;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_action_ff <= ACT_WR_SRC;
      end else begin
         last_action_ff <= last_action_in;
      end
   end

   `BOCP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data) && $stable(rsp_status), "stalled response changed")
   `BOCP_ASSERT_NOW(a_one_slot, clock, reset, req_fire, !rsp_valid || rsp_ready, "request taken over an unread response")
   `BOCP_ASSERT_NEXT(a_write_rsp, clock, reset, req_fire && is_write, rsp_valid, "write request not answered next cycle")
   `BOCP_ASSERT_NOW(a_data_zero, clock, reset, rsp_valid && (last_action_ff != ACT_RD_DST || rsp_status), rsp_read_data == 8'd0, "nonzero data on a non-read response")

endmodule

bind bit_offset_copy_engine_top bocp_checker u_bocp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_action    (req_chan.action),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_read_data (rsp_chan.read_data),
   .rsp_status    (rsp_chan.status)
);

`default_nettype wire
